// ----- src/deq_pkg.sv -----
// ============================================================================
// Double-ended queue package
// Field widths, operation codes and status codes shared by the channel
// interfaces and the queue core.
// ============================================================================
package deq_pkg;

   // Payload field widths.
   localparam int FUNC_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // Operation codes carried in the func field of a request.
   typedef enum logic [FUNC_W-1:0] {
      FN_INS_FRONT = 3'd0,
      FN_INS_REAR  = 3'd1,
      FN_DEL_FRONT = 3'd2,
      FN_DEL_REAR  = 3'd3,
      FN_DISPLAY   = 3'd4
   } func_type;

   // Status codes carried in each response.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

// ----- src/deq_if.sv -----
// ============================================================================
// Double-ended queue channel interfaces
// Valid/ready channels for requests into the queue and responses out of it.
// ============================================================================

// Request channel: one operation with its insert value.
interface deq_req_if;
   import deq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [FUNC_W-1:0]          func;
   logic signed [VALUE_W-1:0]  value_in;

   modport source (output valid, input ready, output func, output value_in);
   modport sink   (input valid, output ready, input func, input value_in);
endinterface

// Response channel: one result value with its status and end marker.
interface deq_rsp_if;
   import deq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  value_out;
   logic [STATUS_W-1:0]        status;
   logic                       last;

   modport source (output valid, input ready, output value_out, output status, output last);
   modport sink   (input valid, output ready, input value_out, input status, input last);
endinterface

// ----- src/double_ended_queue_core.sv -----
// ============================================================================
// Double-ended queue core
// Bounded deque of signed 32-bit values in a circular single-port-read store,
// tracked by a front index and an entry count.
// ============================================================================
// An insert, or any request that meets a full or empty queue, gives its
// response in the cycle after acceptance; a delete's response passes the
// store's registered read data, then the response register. Display of N
// entries gives its first response the same way, then one per cycle while
// the response channel does not stall, paced by the store's single read port;
// one request is in work at a time. Reset clears the indices and control;
// store contents are undefined until written and no clearing pass is made.
module double_ended_queue_core #(
   parameter int DEPTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   deq_req_if.sink   req_chan,
   deq_rsp_if.source rsp_chan
);
   import deq_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   typedef enum logic {
      S_IDLE,
      S_RUN
   } state_type;

   // Circular position front + offset, both below DEPTH.
   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] offset);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= (IDX_W+1)'(DEPTH)) begin
         sum = sum - (IDX_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   // Entry store.
   logic signed [VALUE_W-1:0] mem [DEPTH];
   logic                      mem_we;
   logic                      mem_re;
   logic [IDX_W-1:0]          mem_waddr;
   logic [IDX_W-1:0]          mem_raddr;
   logic signed [VALUE_W-1:0] rd_data_ff;

   // Control state.
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  front_ff, front_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  off_ff, off_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              rd_last_ff, rd_last_in;

   // Response register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic                      last_ff, last_in;

   logic             req_fire;
   logic             out_free;
   logic             move;
   logic             is_empty;
   logic             is_full;
   logic [IDX_W-1:0] front_dec;
   logic [IDX_W-1:0] front_inc;
   logic [IDX_W-1:0] rear_slot;
   logic [IDX_W-1:0] back_slot;

   // Handshake and derived positions.
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && out_free;
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign move      = rd_pend_ff && out_free;
   assign is_empty  = (cnt_ff == '0);
   assign is_full   = (cnt_ff == FULL_CNT);
   assign front_dec = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
   assign front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;
   assign rear_slot = wrap_add(front_ff, IDX_W'(cnt_ff));
   assign back_slot = wrap_add(front_ff, IDX_W'(cnt_ff - 1'b1));

   // Next-state logic. Inserts write in the accept cycle and reads only follow
   // in later cycles, so a read never meets a write to the same entry.
   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      cnt_in       = cnt_ff;
      off_in       = off_ff;
      left_in      = left_ff;
      rd_pend_in   = rd_pend_ff;
      rd_last_in   = rd_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      value_in     = value_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = '0;
      mem_raddr    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_chan.func)
                  FN_INS_FRONT, FN_INS_REAR: begin
                     rsp_valid_in = 1'b1;
                     value_in     = '0;
                     last_in      = 1'b1;
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        status_in = ST_OK;
                        mem_we    = 1'b1;
                        cnt_in    = cnt_ff + 1'b1;
                        if (req_chan.func == FN_INS_FRONT) begin
                           mem_waddr = front_dec;
                           front_in  = front_dec;
                        end else begin
                           mem_waddr = rear_slot;
                        end
                     end
                  end
                  FN_DEL_FRONT, FN_DEL_REAR, FN_DISPLAY: begin
                     if (is_empty) begin
                        rsp_valid_in = 1'b1;
                        value_in     = '0;
                        status_in    = ST_EMPTY;
                        last_in      = 1'b1;
                     end else begin
                        mem_re     = 1'b1;
                        rd_pend_in = 1'b1;
                        state_in   = S_RUN;
                        if (req_chan.func == FN_DISPLAY) begin
                           mem_raddr  = front_ff;
                           rd_last_in = (cnt_ff == CNT_W'(1));
                           left_in    = cnt_ff - 1'b1;
                           off_in     = IDX_W'(1);
                        end else begin
                           rd_last_in = 1'b1;
                           left_in    = '0;
                           cnt_in     = cnt_ff - 1'b1;
                           if (req_chan.func == FN_DEL_FRONT) begin
                              mem_raddr = front_ff;
                              front_in  = front_inc;
                           end else begin
                              mem_raddr = back_slot;
                           end
                        end
                     end
                  end
                  default: begin
                     // Unused codes are taken and dropped without a response.
                  end
               endcase
            end
         end
         S_RUN: begin
            // Move read data into the response register when it is free.
            if (move) begin
               rsp_valid_in = 1'b1;
               value_in     = rd_data_ff;
               status_in    = ST_OK;
               last_in      = rd_last_ff;
               rd_pend_in   = 1'b0;
            end
            // Issue the next display read once the read register can be refilled.
            if ((left_ff != '0) && (!rd_pend_ff || move)) begin
               mem_re     = 1'b1;
               mem_raddr  = wrap_add(front_ff, off_ff);
               off_in     = off_ff + 1'b1;
               left_in    = left_ff - 1'b1;
               rd_last_in = (left_ff == CNT_W'(1));
               rd_pend_in = 1'b1;
            end
            if ((left_ff == '0) && move) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         cnt_ff       <= '0;
         off_ff       <= '0;
         left_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rd_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         cnt_ff       <= cnt_in;
         off_ff       <= off_in;
         left_ff      <= left_in;
         rd_pend_ff   <= rd_pend_in;
         rd_last_ff   <= rd_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff  <= value_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   // Store write port and registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= req_chan.value_in;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // Response outputs.
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.value_out = value_ff;
   assign rsp_chan.status    = status_ff;
   assign rsp_chan.last      = last_ff;

   // An insert into a full queue leaves the entry count alone.
   a_full_insert_holds: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_full &&
       (req_chan.func == FN_INS_FRONT || req_chan.func == FN_INS_REAR))
      |=> $stable(cnt_ff))
      else $error("insert into a full queue changed the entry count");

   // Pending read data only exists while a read sequence is running.
   a_pend_in_run: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == S_RUN))
      else $error("read data pending outside the run state");

   // A delete on a non-empty queue starts a store read at once.
   a_delete_reads: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !is_empty &&
       (req_chan.func == FN_DEL_FRONT || req_chan.func == FN_DEL_REAR))
      |=> (rd_pend_ff && state_ff == S_RUN && left_ff == '0))
      else $error("delete did not start a single store read");

   // After each accepted request the entry count does not exceed the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (cnt_ff <= FULL_CNT))
      else $error("entry count beyond store depth");

endmodule
